/* sv/ppmfg_pkg.sv */
package ppmfg_pkg;

  // default table depth
  localparam int MAX_CHANNELS_DEF = 16;

  // configuration reset values
  localparam logic [4:0]  CHANNEL_COUNT_RST = 5'd8;
  localparam logic [14:0] PULSE_LENGTH_RST  = 15'd250;
  localparam logic [14:0] PAUSE_LENGTH_RST  = 15'd5250;
  localparam logic        INVERT_RST        = 1'b0;

  // frame timing after reset, in half-microsecond ticks
  localparam logic [15:0] FRAME_PULSE_RST = 16'd500;
  localparam logic [15:0] FRAME_PAUSE_RST = 16'd10500;

  // configuration register indexes
  typedef enum logic [1:0] {
    CFG_CHANNEL_COUNT = 2'd0,
    CFG_PULSE_LENGTH  = 2'd1,
    CFG_PAUSE_LENGTH  = 2'd2,
    CFG_INVERT        = 2'd3
  } cfg_reg_t;

  // channel width write into the live table
  typedef struct packed {
    logic        en;
    logic [3:0]  idx;
    logic [15:0] ticks;
  } tbl_wr_t;

  // per-tick result
  typedef struct packed {
    logic       pin_level;
    logic       frame_start;
    logic [5:0] segment_index;
  } tick_res_t;

endpackage

/* sv/ppmfg_tbl.sv */
module ppmfg_tbl
  import ppmfg_pkg::*;
#(
  parameter int MAX_CHANNELS = MAX_CHANNELS_DEF,
  parameter int IDX_W        = 4
) (
  input  logic              clk,
  input  logic              rst,
  input  tbl_wr_t           wr,
  input  logic              latch,
  input  logic [IDX_W-1:0]  rd_idx,
  output logic [15:0]       rd_data
);

  logic [15:0] live_widths  [MAX_CHANNELS];
  logic [15:0] frame_widths [MAX_CHANNELS];
  logic [5:0]  wr_idx_ext;
  logic        wr_hit;

  // writes beyond the table depth are dropped
  assign wr_idx_ext = 6'(wr.idx);
  assign wr_hit     = wr.en && (wr_idx_ext < 6'(MAX_CHANNELS));

  // live table, written by width requests
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MAX_CHANNELS; i++) live_widths[i] <= '0;
    end else if (wr_hit) begin
      live_widths[wr_idx_ext[IDX_W-1:0]] <= wr.ticks;
    end
  end

  // frame table, copied from the live table at frame end
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MAX_CHANNELS; i++) frame_widths[i] <= '0;
    end else if (latch) begin
      for (int i = 0; i < MAX_CHANNELS; i++) frame_widths[i] <= live_widths[i];
    end
  end

  assign rd_data = frame_widths[rd_idx];

endmodule

/* sv/ppmfg_seq.sv */
module ppmfg_seq
  import ppmfg_pkg::*;
#(
  parameter int MAX_CHANNELS = MAX_CHANNELS_DEF,
  parameter int IDX_W        = 4
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              tick,
  input  logic [4:0]        channel_count,
  input  logic [14:0]       pulse_length,
  input  logic [14:0]       pause_length,
  input  logic              invert,
  output logic              latch,
  output logic [IDX_W-1:0]  rd_idx,
  input  logic [15:0]       rd_data,
  output tick_res_t         res
);

  localparam int FC_W  = $clog2(MAX_CHANNELS + 1);
  localparam int POS_W = $clog2(2 * MAX_CHANNELS + 2);
  localparam logic [FC_W-1:0] FC_RST =
    FC_W'((int'(CHANNEL_COUNT_RST) > MAX_CHANNELS) ? MAX_CHANNELS
                                                    : int'(CHANNEL_COUNT_RST));

  logic [FC_W-1:0]  frame_channels;
  logic [15:0]      frame_pulse;
  logic [15:0]      frame_pause;
  logic [POS_W-1:0] segment_pos;
  logic [15:0]      ticks_left;

  logic [15:0]      pulse_len;
  logic [15:0]      ticks_dec;
  logic [POS_W-1:0] two_fc;
  logic [POS_W-1:0] pos_inc;
  logic             last_seg;
  logic [15:0]      gap_len;
  logic [15:0]      pause_len;
  logic [15:0]      next_len;
  logic [15:0]      new_pulse_len;
  logic [5:0]       count_ext;
  logic [FC_W-1:0]  fc_latch;
  logic [POS_W+5:0] pos_ext;

  // length of a span less the pulse, never below one tick
  function automatic logic [15:0] at_least_one(input logic [15:0] total,
                                               input logic [15:0] minus);
    logic [15:0] diff;
    diff = total - minus;
    return (total <= minus) ? 16'd1 : diff;
  endfunction

  // segment bookkeeping
  assign pulse_len = (frame_pulse == '0) ? 16'd1 : frame_pulse;
  assign ticks_dec = ticks_left - 16'd1;
  assign two_fc    = POS_W'({frame_channels, 1'b0});
  assign pos_inc   = segment_pos + 1'b1;
  assign last_seg  = (segment_pos == two_fc + 1'b1);
  assign rd_idx    = IDX_W'(pos_inc >> 1);
  assign gap_len   = at_least_one(rd_data, frame_pulse);
  assign pause_len = at_least_one(frame_pause, frame_pulse);

  // length of the segment that follows, with this frame's timing
  always_comb begin
    if (pos_inc < two_fc) begin
      next_len = pos_inc[0] ? gap_len : pulse_len;
    end else if (pos_inc == two_fc) begin
      next_len = pulse_len;
    end else begin
      next_len = pause_len;
    end
  end

  // timing latched for the next frame
  assign new_pulse_len = (pulse_length == '0) ? 16'd1 : {pulse_length, 1'b0};
  assign count_ext     = 6'(channel_count);
  assign fc_latch      = (count_ext > 6'(MAX_CHANNELS)) ? FC_W'(MAX_CHANNELS)
                                                        : FC_W'(channel_count);
  assign latch         = tick && (ticks_dec == '0) && last_seg;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_channels <= FC_RST;
      frame_pulse    <= FRAME_PULSE_RST;
      frame_pause    <= FRAME_PAUSE_RST;
      segment_pos    <= '0;
      ticks_left     <= FRAME_PULSE_RST;
    end else if (tick) begin
      if (ticks_dec != '0) begin
        ticks_left <= ticks_dec;
      end else if (last_seg) begin
        segment_pos    <= '0;
        frame_channels <= fc_latch;
        frame_pulse    <= {pulse_length, 1'b0};
        frame_pause    <= {pause_length, 1'b0};
        ticks_left     <= new_pulse_len;
      end else begin
        segment_pos <= pos_inc;
        ticks_left  <= next_len;
      end
    end
  end

  // result for the current tick
  assign pos_ext           = {6'd0, segment_pos};
  assign res.pin_level     = segment_pos[0] ? ~invert : invert;
  assign res.frame_start   = (segment_pos == '0) && (ticks_left == pulse_len);
  assign res.segment_index = pos_ext[5:0];

  a_ticks_nonzero: assert property (@(posedge clk) disable iff (rst)
    ticks_left != '0)
    else $error("segment timer reached zero");

  a_pos_in_frame: assert property (@(posedge clk) disable iff (rst)
    segment_pos <= two_fc + 1'b1)
    else $error("segment position beyond frame end");

  a_latch_wraps: assert property (@(posedge clk) disable iff (rst)
    latch |=> segment_pos == '0)
    else $error("frame latch without return to first segment");

endmodule

/* sv/ppm_frame_generator.sv */
// PPM frame generator: drives an RC pulse position frame, one tick at a time.
// Input channel (in_valid/in_ready): cmd=1 stores channel_width (microseconds)
//   for channel_index in the live table and gives no result; cmd=0 is one
//   half-microsecond tick and gives one result.
// Output channel (out_valid/out_ready): pin_level, frame_start on the first
//   tick of a frame, and segment_index (even = pulse, odd = gap or pause).
// Configuration channel (cfg_valid/cfg_ready, cfg_index, cfg_data): channel
//   count, pulse length, pause length, invert; always ready, write while idle.
// Latency: a tick's result is shown the cycle after the request is taken.
// Throughput: one request per cycle; the segment timer and step are a single
//   decrement and compare, and the result register frees in the cycle it is read.
// Stall: while a result waits with out_ready low, in_ready is low; the
//   request is taken in the same cycle the waiting result is read.
// Reset: widths zero, 8 channels, 250 us pulse, 5250 us pause, no invert;
//   the frame starts at the first pulse. Timing is latched at each frame end.
module ppm_frame_generator
  import ppmfg_pkg::*;
#(
  parameter int MAX_CHANNELS = MAX_CHANNELS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        cmd,
  input  logic [3:0]  channel_index,
  input  logic [14:0] channel_width,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        pin_level,
  output logic        frame_start,
  output logic [5:0]  segment_index,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [14:0] cfg_data
);

  localparam int IDX_W = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;

  logic [4:0]       channel_count;
  logic [14:0]      pulse_length;
  logic [14:0]      pause_length;
  logic             invert;
  logic             in_acc;
  logic             tick;
  tbl_wr_t          wr;
  logic             latch;
  logic [IDX_W-1:0] rd_idx;
  logic [15:0]      rd_data;
  tick_res_t        res;
  cfg_reg_t         cfg_sel;

  // configuration registers
  assign cfg_ready = 1'b1;
  assign cfg_sel   = cfg_reg_t'(cfg_index);

  always_ff @(posedge clk) begin
    if (rst) begin
      channel_count <= CHANNEL_COUNT_RST;
      pulse_length  <= PULSE_LENGTH_RST;
      pause_length  <= PAUSE_LENGTH_RST;
      invert        <= INVERT_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_sel)
        CFG_CHANNEL_COUNT: channel_count <= cfg_data[4:0];
        CFG_PULSE_LENGTH:  pulse_length  <= cfg_data;
        CFG_PAUSE_LENGTH:  pause_length  <= cfg_data;
        CFG_INVERT:        invert        <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // request handshake
  assign in_ready = !out_valid || out_ready;
  assign in_acc   = in_valid && in_ready;
  assign tick     = in_acc && !cmd;

  assign wr.en    = in_acc && cmd;
  assign wr.idx   = channel_index;
  assign wr.ticks = {channel_width, 1'b0};

  ppmfg_tbl #(
    .MAX_CHANNELS (MAX_CHANNELS),
    .IDX_W        (IDX_W)
  ) u_tbl (
    .clk     (clk),
    .rst     (rst),
    .wr      (wr),
    .latch   (latch),
    .rd_idx  (rd_idx),
    .rd_data (rd_data)
  );

  ppmfg_seq #(
    .MAX_CHANNELS (MAX_CHANNELS),
    .IDX_W        (IDX_W)
  ) u_seq (
    .clk           (clk),
    .rst           (rst),
    .tick          (tick),
    .channel_count (channel_count),
    .pulse_length  (pulse_length),
    .pause_length  (pause_length),
    .invert        (invert),
    .latch         (latch),
    .rd_idx        (rd_idx),
    .rd_data       (rd_data),
    .res           (res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (tick) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (tick) begin
      pin_level     <= res.pin_level;
      frame_start   <= res.frame_start;
      segment_index <= res.segment_index;
    end
  end

  a_tick_result: assert property (@(posedge clk) disable iff (rst)
    tick |=> out_valid)
    else $error("tick request gave no result");

  a_write_silent: assert property (@(posedge clk) disable iff (rst)
    (in_acc && cmd) |=> !out_valid)
    else $error("width write gave a result");

  a_start_first_seg: assert property (@(posedge clk) disable iff (rst)
    (out_valid && frame_start) |-> segment_index == 6'd0)
    else $error("frame start outside first segment");

endmodule

/* tb/sv/ppm_frame_checker.sv */
`timescale 1ns / 1ps

module ppm_frame_checker
  import ppmfg_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic        cmd,
  input  logic [3:0]  channel_index,
  input  logic [14:0] channel_width,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic        pin_level,
  input  logic        frame_start,
  input  logic [5:0]  segment_index,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [14:0] cfg_data,
  output int          fail_count,
  output int          pending
);

  localparam int NCH = MAX_CHANNELS_DEF;

  // shadow copies of the registers
  logic [4:0]  chan_cnt;
  logic [14:0] pulse_us;
  logic [14:0] pause_us;
  logic        inv;

  // live table and the timing latched for the running frame
  logic [15:0] live_tbl [NCH];
  logic [15:0] frm_tbl [NCH];
  int          frm_chans;
  logic [15:0] frm_pulse;
  logic [15:0] frm_pause;
  int          seg;
  int          ticks;

  // tick results still owed by the block, oldest first
  tick_res_t   level_q [$];

  // a segment never lasts less than one tick
  function automatic int floor_one(input int total, input int minus);
    if (total <= minus) return 1;
    return total - minus;
  endfunction

  function automatic int seg_ticks(input int pos);
    int pulse;
    pulse = (frm_pulse != 16'd0) ? int'(frm_pulse) : 1;
    if (pos < 2 * frm_chans) begin
      if (pos % 2 == 0) return pulse;
      return floor_one(int'(frm_tbl[(pos / 2) % NCH]), int'(frm_pulse));
    end
    if (pos == 2 * frm_chans) return pulse;
    return floor_one(int'(frm_pause), int'(frm_pulse));
  endfunction

  // frame end: take over the live widths and the register values
  function automatic void latch_frame();
    for (int i = 0; i < NCH; i++) frm_tbl[i] = live_tbl[i];
    frm_chans = (int'(chan_cnt) > NCH) ? NCH : int'(chan_cnt);
    frm_pulse = {pulse_us, 1'b0};
    frm_pause = {pause_us, 1'b0};
  endfunction

  function automatic void clear_state();
    chan_cnt = CHANNEL_COUNT_RST;
    pulse_us = PULSE_LENGTH_RST;
    pause_us = PAUSE_LENGTH_RST;
    inv = INVERT_RST;
    for (int i = 0; i < NCH; i++) begin
      live_tbl[i] = '0;
      frm_tbl[i] = '0;
    end
    frm_chans = (int'(CHANNEL_COUNT_RST) > NCH) ? NCH : int'(CHANNEL_COUNT_RST);
    frm_pulse = FRAME_PULSE_RST;
    frm_pause = FRAME_PAUSE_RST;
    seg = 0;
    ticks = seg_ticks(0);
  endfunction

  // level for one tick, then step the segment timer
  function automatic tick_res_t advance_tick();
    tick_res_t r;
    r.pin_level = seg[0] ? ~inv : inv;
    r.frame_start = (seg == 0 && ticks == seg_ticks(0));
    r.segment_index = seg[5:0];
    if (ticks > 0) ticks--;
    if (ticks == 0) begin
      seg++;
      if (seg >= 2 * frm_chans + 2) begin
        seg = 0;
        latch_frame();
      end
      ticks = seg_ticks(seg);
    end
    return r;
  endfunction

  always @(posedge clk) begin
    tick_res_t want;
    int errs;
    errs = 0;
    if (rst) begin
      clear_state();
      level_q.delete();
      fail_count <= 0;
      pending <= 0;
    end else begin
      // compare a returned result with the oldest prediction
      if (out_valid && out_ready) begin
        if (level_q.size() == 0) begin
          $display("%0t: unexpected result pin_level=%0b frame_start=%0b segment_index=%0d",
                   $time, pin_level, frame_start, segment_index);
          errs++;
        end else begin
          want = level_q.pop_front();
          if (pin_level !== want.pin_level) begin
            $display("%0t: pin_level expected %0b actual %0b",
                     $time, want.pin_level, pin_level);
            errs++;
          end
          if (frame_start !== want.frame_start) begin
            $display("%0t: frame_start expected %0b actual %0b",
                     $time, want.frame_start, frame_start);
            errs++;
          end
          if (segment_index !== want.segment_index) begin
            $display("%0t: segment_index expected %0d actual %0d",
                     $time, want.segment_index, segment_index);
            errs++;
          end
        end
      end

      // register writes
      if (cfg_valid && cfg_ready) begin
        case (cfg_reg_t'(cfg_index))
          CFG_CHANNEL_COUNT: chan_cnt = cfg_data[4:0];
          CFG_PULSE_LENGTH:  pulse_us = cfg_data;
          CFG_PAUSE_LENGTH:  pause_us = cfg_data;
          CFG_INVERT:        inv = cfg_data[0];
          default: ;
        endcase
      end

      // accepted request: table write or tick
      if (in_valid && in_ready) begin
        if (cmd) begin
          if (int'(channel_index) < NCH) live_tbl[channel_index] = {channel_width, 1'b0};
        end else begin
          level_q.push_back(advance_tick());
        end
      end

      fail_count <= fail_count + errs;
      pending <= level_q.size();
    end
  end

endmodule

/* tb/sv/ppm_frame_generator_test.sv */
`timescale 1ns / 1ps

module ppm_frame_generator_test;
  import ppmfg_pkg::*;

  localparam int NCH = MAX_CHANNELS_DEF;
  localparam int STALL_LIMIT = 2000;
  localparam int LONG_HOLD = 300;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        cmd = 1'b0;
  logic [3:0]  channel_index = '0;
  logic [14:0] channel_width = '0;
  logic        out_ready = 1'b1;
  logic        cfg_valid = 1'b0;
  cfg_reg_t    cfg_index = CFG_CHANNEL_COUNT;
  logic [14:0] cfg_data = '0;

  logic        in_ready;
  logic        out_valid;
  logic        pin_level;
  logic        frame_start;
  logic [5:0]  segment_index;
  logic        cfg_ready;

  int          fail_count;
  int          pending;

  // idle odds per cycle, 0 means no idling
  int          tx_odds = 0;
  int          rx_odds = 8;
  bit          hold_req = 1'b0;

  ppm_frame_generator dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .cmd           (cmd),
    .channel_index (channel_index),
    .channel_width (channel_width),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .pin_level     (pin_level),
    .frame_start   (frame_start),
    .segment_index (segment_index),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  ppm_frame_checker chk (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .cmd           (cmd),
    .channel_index (channel_index),
    .channel_width (channel_width),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .pin_level     (pin_level),
    .frame_start   (frame_start),
    .segment_index (segment_index),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .fail_count    (fail_count),
    .pending       (pending)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // receiver: random back-pressure bursts and one long hold-off
  initial begin
    bit held;
    int n;
    held = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && !held) begin
        held = 1'b1;
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        out_ready <= 1'b1;
      end else if (rx_odds != 0 && $urandom_range(1, rx_odds) == 1) begin
        n = $urandom_range(1, 19);
        out_ready <= 1'b0;
        repeat (n) @(posedge clk);
        out_ready <= 1'b1;
      end
    end
  end

  // watchdog: cycles with no handshake on any channel
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("** ppm_frame_generator: FAILED **");
    $finish;
  end

  // one request, with an occasional idle burst in front
  task automatic push_req(input logic c, input logic [3:0] idx, input logic [14:0] w);
    int gap;
    if (tx_odds != 0 && $urandom_range(1, tx_odds) == 1) begin
      gap = $urandom_range(1, 19);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    cmd <= c;
    channel_index <= idx;
    channel_width <= w;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic push_tick();
    push_req(1'b0, 4'($urandom_range(0, 15)), 15'($urandom_range(0, 32767)));
  endtask

  // stop sending and wait until every tick has its level back
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // write all four registers, unused upper bits filled with noise
  task automatic load_settings(input logic [4:0] cc, input logic [14:0] pl,
                               input logic [14:0] pa, input logic inv);
    logic [14:0] vals [4];
    vals[0] = {10'($urandom), cc};
    vals[1] = pl;
    vals[2] = pa;
    vals[3] = {14'($urandom), inv};
    for (int k = 0; k < 4; k++) begin
      cfg_valid <= 1'b1;
      cfg_index <= cfg_reg_t'(k);
      cfg_data <= vals[k];
      do @(posedge clk); while (!cfg_ready);
    end
    cfg_valid <= 1'b0;
  endtask

  // reload the table with short widths, switch settings, then mixed traffic;
  // channels outside the frame may carry any width
  task automatic run_phase(input int cc, input int pl, input int pa, input bit inv,
                           input int n_items, input int tx, input int rx);
    int act;
    int wmax;
    int idx;
    logic [14:0] w;
    act = (cc > NCH) ? NCH : cc;
    wmax = (pl + 4 > 32767) ? 32767 : pl + 4;
    settle();
    for (int i = 0; i < NCH; i++) push_req(1'b1, 4'(i), 15'($urandom_range(0, wmax)));
    settle();
    load_settings(5'(cc), 15'(pl), 15'(pa), inv);
    tx_odds = tx;
    rx_odds <= rx;
    for (int n = 0; n < n_items; n++) begin
      if ($urandom_range(0, 99) < 88) begin
        push_tick();
      end else begin
        idx = $urandom_range(0, NCH - 1);
        if (idx < act)
          w = 15'($urandom_range(0, wmax));
        else if ($urandom_range(0, 3) == 0)
          w = 15'h7fff;
        else
          w = 15'($urandom_range(0, 32767));
        push_req(1'b1, 4'(idx), w);
      end
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // short frames for after the reset frame ends
    load_settings(5'd4, 15'd2, 15'd10, 1'b0);

    // directed: field extremes on ticks and table writes
    push_req(1'b0, 4'h0, 15'h0000);
    push_req(1'b0, 4'hf, 15'h7fff);
    push_req(1'b1, 4'hf, 15'h7fff);
    push_req(1'b1, 4'h4, 15'h0000);
    push_req(1'b1, 4'ha, 15'h5555);
    push_req(1'b1, 4'h5, 15'h2aaa);
    // width below, equal to and above the pulse
    push_req(1'b1, 4'h0, 15'd0);
    push_req(1'b1, 4'h1, 15'd2);
    push_req(1'b1, 4'h2, 15'd3);
    push_req(1'b1, 4'h3, 15'd9);
    repeat (8) push_tick();
    push_req(1'b1, 4'h1, 15'd1);
    repeat (4) push_tick();

    // run out the reset frame; receiver holds off early so input backs up
    hold_req <= 1'b1;
    for (int k = 0; k < 14600; k++) begin
      if (k == 1000) tx_odds = 12;
      push_tick();
    end

    // wide frame, zero channels, oversize counts, short and zero segments
    run_phase(16, 3, 20, 1'b0, 150, 6, 8);
    run_phase(0, 2, 5, 1'b1, 80, 10, 4);
    run_phase(31, 1, 1, 1'b0, 150, 4, 12);
    run_phase(17, 5, 2, 1'b1, 150, 8, 8);
    run_phase(3, 0, 3, 1'b0, 80, 6, 6);
    repeat (2) begin
      run_phase($urandom_range(1, 16), $urandom_range(1, 4), $urandom_range(1, 40),
                1'($urandom_range(0, 1)), 100, 5, 10);
    end

    // tail without idling, ending on the largest timing values
    run_phase($urandom_range(1, 16), $urandom_range(1, 4), $urandom_range(1, 40),
              1'($urandom_range(0, 1)), 100, 0, 0);
    run_phase(31, 32767, 32767, 1'b1, 60, 0, 0);

    settle();
    repeat (20) @(posedge clk);
    if (fail_count == 0 && pending == 0)
      $display("** ppm_frame_generator: PASSED **");
    else
      $display("** ppm_frame_generator: FAILED **");
    $finish;
  end

endmodule
